[src/sti_pkg.sv]
// ----------------------------------------------------------------------------
// Signed table interpolation package
// Shared widths, codes and types for the interpolation pipeline.
// ----------------------------------------------------------------------------
package sti_pkg;

   localparam int unsigned MAX_POINTS_DEF = 16;
   localparam int unsigned COORD_W        = 16;
   localparam int unsigned COUNT_W        = 5;
   localparam int unsigned INDEX_W        = 4;
   localparam int unsigned FRAC_SHIFT     = 4;
   localparam int unsigned DIFF_W         = COORD_W + 1;
   localparam int unsigned PROD_W         = 2 * DIFF_W;
   localparam int unsigned MAG_W          = 2 * COORD_W;
   localparam int unsigned NUM_W          = MAG_W + FRAC_SHIFT;
   localparam int unsigned QUOT_W         = COORD_W + FRAC_SHIFT + 2;
   localparam int unsigned DIV_W          = QUOT_W + COORD_W;
   localparam int unsigned ACC_W          = QUOT_W + 2;
   localparam int unsigned REQ_DATA_W     = 56;
   localparam int unsigned RSP_DATA_W     = 16;

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_QUERY = 1'b1
   } action_type;

   // Values that ride alongside the division.
   typedef struct packed {
      logic                      neg;
      logic                      den_zero;
      logic signed [COORD_W-1:0] y0;
   } div_side_type;

endpackage

[src/sti_divider.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, magnitude operands, side data carried along.
// ----------------------------------------------------------------------------
module sti_divider
   import sti_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [COORD_W-1:0] in_den,
   input  div_side_type       in_side,
   output logic               out_valid,
   output logic [QUOT_W-1:0]  out_quot,
   output div_side_type       out_side
);

   logic [QUOT_W-1:0]  valid_ff;
   logic [DIV_W-1:0]   rem_ff  [QUOT_W];
   logic [COORD_W-1:0] den_ff  [QUOT_W];
   logic [QUOT_W-1:0]  quot_ff [QUOT_W];
   div_side_type       side_ff [QUOT_W];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      logic               v_in;
      logic [DIV_W-1:0]   r_in;
      logic [COORD_W-1:0] d_in;
      logic [QUOT_W-1:0]  q_in;
      div_side_type       s_in;
      logic [DIV_W-1:0]   shifted;
      logic               take;

      if (k == 0) begin : g_first
         assign v_in = in_valid;
         assign r_in = DIV_W'(in_num);
         assign d_in = in_den;
         assign q_in = '0;
         assign s_in = in_side;
      end else begin : g_next
         assign v_in = valid_ff[k-1];
         assign r_in = rem_ff[k-1];
         assign d_in = den_ff[k-1];
         assign q_in = quot_ff[k-1];
         assign s_in = side_ff[k-1];
      end

      assign shifted = DIV_W'(d_in) << (QUOT_W - 1 - k);
      assign take    = (r_in >= shifted);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= v_in;
         end
         if (advance) begin
            rem_ff[k]  <= take ? (r_in - shifted) : r_in;
            den_ff[k]  <= d_in;
            quot_ff[k] <= q_in | (QUOT_W'(take) << (QUOT_W - 1 - k));
            side_ff[k] <= s_in;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_quot  = quot_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

[src/signed_table_interpolation_unit.sv]
// Query path: input, segment select, differences, product, magnitude, divider, s5, output.
// Throughput: one item per cycle when not stalled; the 22-stage divider sets the latency.
// Writes update the table from the input register when it advances and return no result.
// Reset is synchronous and active high: it clears all valid bits and sets count_ff to 2.
// The breakpoint table is not cleared by reset.
// ----------------------------------------------------------------------------
// Signed table interpolation unit
// Piecewise-linear lookup over up to MaxPoints signed breakpoints.
// ----------------------------------------------------------------------------
module signed_table_interpolation_unit
   import sti_pkg::*;
#(
   parameter int unsigned MaxPoints = MAX_POINTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [COUNT_W-1:0]    csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_index[3:0], point_x[19:4], point_y[35:20], query_x[51:36], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // result_y[15:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int unsigned IdxW = $clog2(MaxPoints);
   localparam int unsigned CntW = $clog2(MaxPoints + 1);

   logic                      advance;
   logic [COUNT_W-1:0]        count_ff;
   logic signed [COORD_W-1:0] bx_ff [MaxPoints];
   logic signed [COORD_W-1:0] by_ff [MaxPoints];

   // Input register.
   logic                      s0_valid_ff;
   action_type                s0_action_ff;
   logic [INDEX_W-1:0]        s0_index_ff;
   logic signed [COORD_W-1:0] s0_px_ff, s0_py_ff, s0_qx_ff;

   // Segment select stage.
   logic                      s1_valid_ff, s1_clamp_ff;
   logic signed [COORD_W-1:0] s1_clamp_y_ff, s1_qx_ff;
   logic signed [COORD_W-1:0] s1_x0_ff, s1_x1_ff, s1_y0_ff, s1_y1_ff;

   // Differences stage.
   logic                      s2_valid_ff;
   logic signed [DIFF_W-1:0]  s2_dy_ff, s2_dx_ff, s2_dn_ff;
   logic signed [COORD_W-1:0] s2_y0_ff;

   // Product stage.
   logic                      s3_valid_ff;
   logic signed [PROD_W-1:0]  s3_prod_ff;
   logic signed [DIFF_W-1:0]  s3_dn_ff;
   logic signed [COORD_W-1:0] s3_y0_ff;

   // Magnitude stage.
   logic                      s4_valid_ff;
   logic [NUM_W-1:0]          s4_num_ff;
   logic [COORD_W-1:0]        s4_den_ff;
   div_side_type              s4_side_ff;

   logic                      div_valid;
   logic [QUOT_W-1:0]         div_quot;
   div_side_type              div_side;

   logic                      s5_valid_ff;
   logic signed [ACC_W-1:0]   s5_acc_ff;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_W-1:0]     rsp_data_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(2);
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req_tvalid;
      end
      if (advance) begin
         s0_action_ff <= action_type'(req_tuser);
         s0_index_ff  <= req_tdata[3:0];
         s0_px_ff     <= req_tdata[19:4];
         s0_py_ff     <= req_tdata[35:20];
         s0_qx_ff     <= req_tdata[51:36];
      end
   end

   // Table write: reads and writes both use the input register, so items keep their order.
   always_ff @(posedge clock) begin
      if (advance && s0_valid_ff && s0_action_ff == ACT_WRITE &&
          32'(s0_index_ff) < MaxPoints) begin
         bx_ff[IdxW'(s0_index_ff)] <= s0_px_ff;
         by_ff[IdxW'(s0_index_ff)] <= s0_py_ff;
      end
   end

   logic [CntW-1:0]           n_eff;
   logic [IdxW-1:0]           last_idx, seg_idx;
   logic                      desc, clamp_lo, clamp_hi;
   logic signed [COORD_W-1:0] x_last;

   always_comb begin
      if (count_ff < COUNT_W'(2)) begin
         n_eff = CntW'(2);
      end else if (32'(count_ff) > MaxPoints) begin
         n_eff = CntW'(MaxPoints);
      end else begin
         n_eff = CntW'(count_ff);
      end
      last_idx = IdxW'(n_eff - CntW'(1));
      x_last   = bx_ff[last_idx];
      desc     = bx_ff[0] > x_last;
      clamp_lo = desc ? (s0_qx_ff >= bx_ff[0]) : (s0_qx_ff <= bx_ff[0]);
      clamp_hi = desc ? (s0_qx_ff <= x_last) : (s0_qx_ff >= x_last);
      // The first segment whose end passes the test wins.
      seg_idx  = last_idx;
      for (int i = MaxPoints - 1; i >= 1; i--) begin
         if (CntW'(i) < n_eff &&
             (desc ? (s0_qx_ff >= bx_ff[i]) : (s0_qx_ff <= bx_ff[i]))) begin
            seg_idx = IdxW'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s0_valid_ff && s0_action_ff == ACT_QUERY;
      end
      if (advance) begin
         s1_clamp_ff   <= clamp_lo || clamp_hi;
         s1_clamp_y_ff <= clamp_lo ? by_ff[0] : by_ff[last_idx];
         s1_qx_ff      <= s0_qx_ff;
         s1_x0_ff      <= bx_ff[seg_idx - IdxW'(1)];
         s1_x1_ff      <= bx_ff[seg_idx];
         s1_y0_ff      <= by_ff[seg_idx - IdxW'(1)];
         s1_y1_ff      <= by_ff[seg_idx];
      end
   end

   // A clamped query becomes a zero slope from its end value.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_dx_ff <= DIFF_W'(s1_qx_ff) - DIFF_W'(s1_x0_ff);
         if (s1_clamp_ff) begin
            s2_dy_ff <= '0;
            s2_dn_ff <= DIFF_W'(1);
            s2_y0_ff <= s1_clamp_y_ff;
         end else begin
            s2_dy_ff <= DIFF_W'(s1_y1_ff) - DIFF_W'(s1_y0_ff);
            s2_dn_ff <= DIFF_W'(s1_x1_ff) - DIFF_W'(s1_x0_ff);
            s2_y0_ff <= s1_y0_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_prod_ff <= PROD_W'(s2_dy_ff) * PROD_W'(s2_dx_ff);
         s3_dn_ff   <= s2_dn_ff;
         s3_y0_ff   <= s2_y0_ff;
      end
   end

   logic signed [PROD_W-1:0] prod_abs;
   logic signed [DIFF_W-1:0] dn_abs;

   assign prod_abs = s3_prod_ff[PROD_W-1] ? -s3_prod_ff : s3_prod_ff;
   assign dn_abs   = s3_dn_ff[DIFF_W-1] ? -s3_dn_ff : s3_dn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_num_ff           <= {prod_abs[MAG_W-1:0], FRAC_SHIFT'(0)};
         s4_den_ff           <= dn_abs[COORD_W-1:0];
         s4_side_ff.neg      <= s3_prod_ff[PROD_W-1] ^ s3_dn_ff[DIFF_W-1];
         s4_side_ff.den_zero <= (s3_dn_ff == '0);
         s4_side_ff.y0       <= s3_y0_ff;
      end
   end

   sti_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid_ff),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_side   (s4_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   logic signed [ACC_W-1:0] quot_ext;
   assign quot_ext = div_side.den_zero ? '0 : signed'(ACC_W'(div_quot));

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (advance) begin
         s5_valid_ff <= div_valid;
      end
      if (advance) begin
         s5_acc_ff <= (ACC_W'(div_side.y0) <<< FRAC_SHIFT) +
                      (div_side.neg ? -quot_ext : quot_ext);
      end
   end

   // Division by the scale truncates toward zero.
   logic signed [ACC_W-1:0] acc_adj, acc_div;

   assign acc_adj = s5_acc_ff + (s5_acc_ff[ACC_W-1] ? ACC_W'(15) : ACC_W'(0));
   assign acc_div = acc_adj >>> FRAC_SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s5_valid_ff;
      end
      if (advance) begin
         if (acc_div > ACC_W'(32767)) begin
            rsp_data_ff <= 16'h7fff;
         end else if (acc_div < -ACC_W'(32768)) begin
            rsp_data_ff <= 16'h8000;
         end else begin
            rsp_data_ff <= acc_div[RSP_DATA_W-1:0];
         end
      end
   end

endmodule

[src/sti_checker.sv]
// ----------------------------------------------------------------------------
// Signed table interpolation checker
// Port-level properties of the interpolation unit, bound to the top level.
// ----------------------------------------------------------------------------
module sti_checker
   import sti_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // No result can appear straight out of reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The whole pipeline moves together, so input ready follows the output side.
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow the output stall");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

endmodule

bind signed_table_interpolation_unit sti_checker u_sti_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
